/* rtl/core/sjfq_pkg.sv */
// ----------------------------------------------------------------------------
// sjfq_pkg
// Types and constants shared by the shortest-job-first ready queue modules.
// ----------------------------------------------------------------------------
package sjfq_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  localparam logic       REQ_INSERT = 1'b0;
  localparam logic       REQ_RUN    = 1'b1;

  localparam logic [1:0] ST_INSERTED   = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  localparam logic [39:0] SUM_MAX = '1;
  localparam logic [15:0] DONE_MAX = '1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] burst;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] job_id;
    logic [15:0] job_burst;
    logic [31:0] arrival;
    logic [31:0] waiting;
    logic [31:0] end_time;
    logic [39:0] total_wait;
    logic [15:0] jobs_done;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] burst;
    logic [15:0] id;
    logic [31:0] arrival;
  } slot_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ACK,
    EM_FULL,
    EM_EMPTY,
    EM_DISP
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    logic  rd_prev;
    logic  shift_wr;
    logic  ins_wr;
    logic  run_step;
    logic  run_end;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic req_type;
    logic full;
    logic empty;
    logic k_zero;
    logic less;
    logic last_job;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/sjfq_ctrl.sv */
// ----------------------------------------------------------------------------
// sjfq_ctrl
// Sequencer for sorted insertion and queue drain.
// ----------------------------------------------------------------------------
module sjfq_ctrl import sjfq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_RCALC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.emit   = EM_NONE;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.req_type == REQ_INSERT) begin
          if (stat.full) begin
            if (stat.out_free) begin
              cmd.emit   = EM_FULL;
              state_next = S_IDLE;
            end
          end else if (stat.k_zero) begin
            if (stat.out_free) begin
              cmd.emit   = EM_ACK;
              cmd.ins_wr = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
            state_next  = S_CMP;
          end
        end else begin
          if (stat.empty) begin
            if (stat.out_free) begin
              cmd.emit   = EM_EMPTY;
              state_next = S_IDLE;
            end
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_RCALC;
          end
        end
      end
      S_CMP: begin
        if (stat.less) begin
          cmd.shift_wr = 1'b1;
          state_next   = S_DECIDE;
        end else if (stat.out_free) begin
          cmd.emit   = EM_ACK;
          cmd.ins_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RCALC: begin
        if (stat.out_free) begin
          cmd.emit     = EM_DISP;
          cmd.run_step = 1'b1;
          if (stat.last_job) begin
            cmd.run_end = 1'b1;
            state_next  = S_IDLE;
          end else begin
            state_next = S_DECIDE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/sjfq_dp.sv */
// ----------------------------------------------------------------------------
// sjfq_dp
// Queue memory, clock and totals, and the output register.
// ----------------------------------------------------------------------------
module sjfq_dp import sjfq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_word,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_word
);

  slot_t mem [MAX_JOBS];
  slot_t rd_data;

  logic              req_type;
  logic [15:0]       burst;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  k_prev;
  logic [CNT_W-1:0]  k_inc;
  logic [CNT_W-1:0]  occupancy;
  logic [31:0]       clock_now;
  logic [15:0]       next_id;
  logic [39:0]       wait_sum;
  logic [15:0]       done_count;

  logic [31:0] wait_cur;
  logic [31:0] clock_next;
  logic [40:0] sum_wide;
  logic [39:0] sum_next;
  logic [15:0] done_next;
  logic [CNT_W-1:0] wr_idx;
  slot_t       wr_data;
  slot_t       new_slot;

  assign k_prev = k - CNT_W'(1);
  assign k_inc  = k + CNT_W'(1);

  assign wait_cur   = clock_now - rd_data.arrival;
  assign clock_next = clock_now + 32'(rd_data.burst);
  assign sum_wide   = {1'b0, wait_sum} + 41'(wait_cur);
  assign sum_next   = sum_wide[40] ? SUM_MAX : sum_wide[39:0];
  assign done_next  = (done_count == DONE_MAX) ? done_count : done_count + 16'd1;

  assign new_slot.burst   = burst;
  assign new_slot.id      = next_id;
  assign new_slot.arrival = clock_now;
  assign wr_idx  = k;
  assign wr_data = cmd.shift_wr ? rd_data : new_slot;

  assign stat.req_type = req_type;
  assign stat.full     = (occupancy == CNT_W'(MAX_JOBS));
  assign stat.empty    = (occupancy == '0);
  assign stat.k_zero   = (k == '0);
  assign stat.less     = (burst < rd_data.burst);
  assign stat.last_job = (k_inc == occupancy);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.shift_wr || cmd.ins_wr) begin
      mem[wr_idx[IDX_W-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= cmd.rd_prev ? mem[k_prev[IDX_W-1:0]] : mem[k[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= in_word.req_type;
      burst    <= in_word.burst;
      k        <= (in_word.req_type == REQ_RUN) ? '0 : occupancy;
    end else if (cmd.shift_wr) begin
      k <= k_prev;
    end else if (cmd.run_step) begin
      k <= k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy  <= '0;
      clock_now  <= '0;
      next_id    <= 16'd1;
      wait_sum   <= '0;
      done_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.ins_wr) begin
        occupancy <= occupancy + CNT_W'(1);
        next_id   <= next_id + 16'd1;
      end else if (cmd.run_end) begin
        occupancy <= '0;
      end
      if (cmd.run_step) begin
        clock_now  <= clock_next;
        wait_sum   <= sum_next;
        done_count <= done_next;
      end
      if (cmd.emit != EM_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_ACK: begin
        out_word <= '{ST_INSERTED, next_id, burst, clock_now, 32'd0, 32'd0,
                      wait_sum, done_count, 1'b1};
      end
      EM_FULL: begin
        out_word <= '{ST_FULL, 16'd0, burst, clock_now, 32'd0, 32'd0,
                      wait_sum, done_count, 1'b1};
      end
      EM_EMPTY: begin
        out_word <= '{ST_EMPTY, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
                      wait_sum, done_count, 1'b1};
      end
      EM_DISP: begin
        out_word <= '{ST_DISPATCHED, rd_data.id, rd_data.burst, rd_data.arrival,
                      wait_cur, clock_next, sum_next, done_next, stat.last_job};
      end
      default: begin
      end
    endcase
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(MAX_JOBS))
    else $error("queue occupancy beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit != EM_NONE && out_valid && !out_ready))
    else $error("result produced while output register is held");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |=> occupancy == $past(occupancy) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.run_end |=> occupancy == '0)
    else $error("queue not empty after run");

endmodule

/* rtl/core/sjf_ready_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// sjf_ready_queue_scheduler
// Non-preemptive shortest-job-first ready queue with sorted insertion.
// ----------------------------------------------------------------------------
// An insert compares its burst with queued jobs from the tail, moving each
// longer job back one slot, then writes the new job; a full queue is refused.
// A run dispatches every queued job in order, then empties the queue; an
// empty queue is reported. The queue memory has a registered read.
// One word is handled at a time; a result waits in the output register.
// Synchronous reset empties the queue, zeroes clock and totals, sets id to 1.
module sjf_ready_queue_scheduler import sjfq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_word,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_word
);

  cmd_t  cmd;
  stat_t stat;

  sjfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sjfq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
